// ----- hw/rtl/smva_pkg.sv -----
// Shared types, constants and float helpers for the SELL matvec block.
package smva_pkg;

	localparam int X_DEPTH = 4096;
	localparam int LANES = 32;
	localparam int XA_W = $clog2(X_DEPTH);
	localparam int LANE_IW = (LANES > 1) ? $clog2(LANES) : 1;

	typedef enum logic [1:0] {
		KIND_XWRITE  = 2'd0,
		KIND_NONZERO = 2'd1,
		KIND_PRELOAD = 2'd2,
		KIND_FLUSH   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ALIGN,
		ST_ADD,
		ST_NORM,
		ST_FLUSH
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic capture;
		logic mul;
		logic align;
		logic add;
		logic norm;
		logic flush_emit;
	} dp_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic flush_done;
	} dp_sts_t;

	// fp32 to bf16, nearest-even, canonical NaN.
	function automatic logic [15:0] fp32_to_bf16(input logic [31:0] w);
		logic [31:0] r;
		begin
			if (w[30:23] == 8'hFF && w[22:0] != 23'd0) begin
				fp32_to_bf16 = 16'h7FC0;
			end else begin
				r = w + 32'h7FFF + {31'd0, w[16]};
				fp32_to_bf16 = r[31:16];
			end
		end
	endfunction

endpackage

// ----- hw/rtl/smva_ctrl.sv -----
// Controller state machine: sequences nonzero arithmetic and flush output.
module smva_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          kind,
	input  smva_pkg::dp_sts_t   sts,
	output smva_pkg::dp_cmd_t   cmd,
	output logic                busy
);
	import smva_pkg::*;

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					if (kind == KIND_NONZERO) state_d = ST_MUL;
					else if (kind == KIND_FLUSH) state_d = ST_FLUSH;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ALIGN;
			end
			ST_ALIGN: begin
				cmd.align = 1'b1;
				state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.add = 1'b1;
				state_d = ST_NORM;
			end
			ST_NORM: begin
				cmd.norm = 1'b1;
				state_d = ST_IDLE;
			end
			ST_FLUSH: begin
				cmd.flush_emit = 1'b1;
				if (sts.flush_done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- hw/rtl/smva_dp.sv -----
// Datapath: x RAM, lane accumulators, bf16 multiply and fp32 add.
module smva_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  smva_pkg::dp_cmd_t   cmd,
	input  logic [1:0]          kind,
	input  logic [4:0]          lane,
	input  logic [11:0]         column_index,
	input  logic [15:0]         operand_bits,
	output smva_pkg::dp_sts_t   sts,
	output logic                result_valid,
	output logic [4:0]          row_lane,
	output logic [15:0]         row_value,
	output logic                last
);
	import smva_pkg::*;

	logic [15:0] x_mem [X_DEPTH];
	logic [31:0] acc_q [LANES];
	logic [LANES-1:0] acc_vld_q;

	logic [15:0] xrd_q, a_q;
	logic        xok_q, lok_q;
	logic [LANE_IW-1:0] ln_q;
	logic [LANE_IW-1:0] fl_q;

	logic col_ok, lane_ok;
	assign col_ok = ({20'd0, column_index} < 32'(X_DEPTH));
	assign lane_ok = ({27'd0, lane} < 32'(LANES));

	// x memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.capture && kind == KIND_XWRITE && col_ok)
			x_mem[column_index[XA_W-1:0]] <= operand_bits;
		xrd_q <= x_mem[column_index[XA_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			a_q <= operand_bits;
			ln_q <= lane[LANE_IW-1:0];
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xok_q <= 1'b0;
			lok_q <= 1'b0;
		end else if (cmd.capture) begin
			xok_q <= col_ok;
			lok_q <= lane_ok;
		end
	end

	// ---- multiply stage: bf16 product as sign/exp/16-bit mantissa, exact unless below the fp32 subnormal step
	logic [15:0] xv;
	assign xv = xok_q ? xrd_q : 16'h0000;
	logic        ps_q, pnan_q, pinf_q, pzero_q;
	logic signed [10:0] pe_q;   // unbiased-ish: value = m * 2^(pe-14-127-127)
	logic [15:0] pm_q;
	always_ff @(posedge clk) begin
		logic [7:0] ea, eb;
		logic [7:0] ma, mb;
		logic an, bn, ai, bi, az, bz;
		logic [15:0] pm, pm_r;
		logic signed [10:0] pe, pe_r, sa;
		logic [31:0] w32, rem32, half32;
		logic ovf;
		if (cmd.mul) begin
			ea = a_q[14:7]; eb = xv[14:7];
			an = (ea == 8'hFF) && (a_q[6:0] != 0);
			bn = (eb == 8'hFF) && (xv[6:0] != 0);
			ai = (ea == 8'hFF) && (a_q[6:0] == 0);
			bi = (eb == 8'hFF) && (xv[6:0] == 0);
			az = (ea == 0) && (a_q[6:0] == 0);
			bz = (eb == 0) && (xv[6:0] == 0);
			ma = {ea != 0, a_q[6:0]};
			mb = {eb != 0, xv[6:0]};
			pm = ma * mb;
			pe = $signed({3'b0, (ea == 0) ? 8'd1 : ea})
				+ $signed({3'b0, (eb == 0) ? 8'd1 : eb});
			// product at or above 2^128 becomes infinity
			ovf = 1'b0;
			sa = 11'sd396 - pe;
			if (pe >= 11'sd396)
				ovf = (pm != 16'd0);
			else if (pe >= 11'sd381)
				ovf = ((pm >> sa[3:0]) != 16'd0);
			// product below the fp32 subnormal step: round to a multiple of 2^-149
			pm_r = pm;
			pe_r = pe;
			if (pe < 11'sd119) begin
				sa = 11'sd119 - pe;
				if (sa > 11'sd16) begin
					pm_r = 16'd0;
				end else begin
					w32 = {16'd0, pm} >> sa[4:0];
					rem32 = {16'd0, pm} & ~(32'hFFFF_FFFF << sa[4:0]);
					half32 = 32'd1 << (sa[4:0] - 5'd1);
					if (rem32 > half32 || (rem32 == half32 && w32[0]))
						w32 = w32 + 32'd1;
					pm_r = w32[15:0];
				end
				pe_r = 11'sd119;
			end
			ps_q <= a_q[15] ^ xv[15];
			pnan_q <= an || bn || (ai && bz) || (bi && az);
			pinf_q <= ai || bi || ovf;
			pzero_q <= az || bz || (pm_r == 16'd0);
			pm_q <= pm_r;
			pe_q <= pe_r;
		end
	end

	// Convert product and accumulator to one extended form. Use common format:
	// Both operands held as sign, exponent E, 48-bit fixed mantissa; value = M*2^(E-BIAS).
	// Product value = pm * 2^(pe - 254 - 14). Accumulator value = m24 * 2^(ea - 150).
	// Use common unit: value = M * 2^(E - 268), E signed.
	logic [31:0] accr;
	assign accr = acc_vld_q[ln_q] ? acc_q[ln_q] : 32'd0;

	// ---- align stage: shift smaller operand right with sticky
	logic        as_q, bs_q, sub_q;
	logic signed [11:0] ebig_q;
	logic [50:0] mbig_q, msml_q;   // 48 value bits + 3 guard
	logic        snan_q, sinf_q, inf_s_q, ovf_nan_q;
	always_ff @(posedge clk) begin
		logic signed [11:0] e_p, e_a, d;
		logic [47:0] m_p, m_a, mb, ms;
		logic sb, ss;
		logic [50:0] sh;
		logic st;
		logic a_nan, a_inf;
		if (cmd.align) begin
			a_nan = (accr[30:23] == 8'hFF) && (accr[22:0] != 0);
			a_inf = (accr[30:23] == 8'hFF) && (accr[22:0] == 0);
			// product: value = pm*2^(pe-268); scale mantissa left by 24
			m_p = {8'd0, pm_q, 24'd0};
			e_p = 12'(pe_q) - 12'sd24;
			// acc: value = m24*2^(ea-150) = (m24<<24)*2^(ea-174)... align to 268 base
			m_a = {accr[30:23] != 0, accr[22:0], 24'd0};
			e_a = $signed({4'b0, (accr[30:23] == 0) ? 8'd1 : accr[30:23]}) + 12'sd94;
			if (pzero_q) begin
				m_p = 48'd0;
				e_p = e_a;
			end
			if (e_a >= e_p) begin
				mb = m_a; ms = m_p; sb = accr[31]; ss = ps_q; d = e_a - e_p;
				ebig_q <= e_a;
			end else begin
				mb = m_p; ms = m_a; sb = ps_q; ss = accr[31]; d = e_p - e_a;
				ebig_q <= e_p;
			end
			if (d > 12'sd50) begin
				st = (ms != 0);
				sh = 51'd0;
			end else begin
				sh = {ms, 3'b0} >> d[5:0];
				st = (({ms, 3'b0} & ~({51{1'b1}} << d[5:0])) != 0);
			end
			mbig_q <= {mb, 3'b0};
			msml_q <= {sh[50:1], sh[0] | st};
			as_q <= sb; bs_q <= ss;
			sub_q <= sb ^ ss;
			snan_q <= pnan_q || a_nan || (pinf_q && a_inf && (ps_q != accr[31]));
			sinf_q <= pinf_q || a_inf;
			inf_s_q <= a_inf ? accr[31] : ps_q;
			ovf_nan_q <= pzero_q && !pinf_q && accr[31] && accr[30:0] == 0;
		end
	end

	// ---- add stage
	logic [51:0] sum_q;
	logic        ssign_q, bothneg0_q;
	always_ff @(posedge clk) begin
		if (cmd.add) begin
			bothneg0_q <= ovf_nan_q && ps_q;
			if (!sub_q) begin
				sum_q <= {1'b0, mbig_q} + {1'b0, msml_q};
				ssign_q <= as_q;
			end else if (mbig_q >= msml_q) begin
				sum_q <= {1'b0, mbig_q - msml_q};
				ssign_q <= as_q;
			end else begin
				sum_q <= {1'b0, msml_q - mbig_q};
				ssign_q <= bs_q;
			end
		end
	end

	// ---- normalize/round stage to fp32 (value = sum * 2^(ebig-268-3))
	logic [5:0] lz;
	always_comb begin
		lz = 6'd52;
		for (int i = 0; i < 52; i++)
			if (sum_q[i]) lz = 6'(51 - i);
	end

	logic [31:0] res;
	always_comb begin
		logic signed [13:0] e;
		logic [51:0] n;
		logic [23:0] m;
		logic g, s;
		logic [24:0] mr;
		logic [51:0] dn;
		logic signed [13:0] sh;
		res = 32'd0;
		m = 24'd0;
		g = 1'b0;
		s = 1'b0;
		mr = 25'd0;
		dn = 52'd0;
		sh = 14'sd0;
		n = sum_q << lz;
		// leading bit at 51: value = 1.x * 2^(ebig - 271 + 51 - lz); fp32 biased = +127
		e = 14'(ebig_q) - 14'sd93 - 14'(lz);
		if (snan_q) res = 32'h7FC00000;
		else if (sinf_q) res = {inf_s_q, 8'hFF, 23'd0};
		else if (sum_q == 0) res = {bothneg0_q, 31'd0};
		else begin
			if (e < 14'sd1) begin
				sh = 14'sd1 - e;
				dn = (sh > 14'sd52) ? 52'd0 : (n >> sh[5:0]);
				s = (sh > 14'sd52) ? 1'b1 : ((n & ~({52{1'b1}} << sh[5:0])) != 0);
				n = {dn[51:1], dn[0] | s};
				e = 14'sd0;
			end
			m = n[51:28];
			g = n[27];
			s = n[26:0] != 0;
			mr = {1'b0, m} + {24'd0, g && (s || m[0])};
			if (mr[24]) begin
				mr = mr >> 1;
				e = e + 14'sd1;
			end else if (e == 14'sd0 && mr[23]) begin
				e = 14'sd1;
			end
			if (e >= 14'sd255) res = {ssign_q, 8'hFF, 23'd0};
			else res = {ssign_q, e[7:0], mr[22:0]};
		end
	end

	// Accumulator array with valid bits; flush clears valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) acc_vld_q <= '0;
		else if (cmd.capture && kind == KIND_PRELOAD && lane_ok)
			acc_vld_q[lane[LANE_IW-1:0]] <= 1'b1;
		else if (cmd.norm && lok_q)
			acc_vld_q[ln_q] <= 1'b1;
		else if (cmd.flush_emit)
			acc_vld_q[fl_q] <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.capture && kind == KIND_PRELOAD && lane_ok)
			acc_q[lane[LANE_IW-1:0]] <= {operand_bits, 16'd0};
		else if (cmd.norm && lok_q)
			acc_q[ln_q] <= res;
	end

	// Flush lane counter and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_q <= '0;
			result_valid <= 1'b0;
			last <= 1'b0;
		end else begin
			result_valid <= cmd.flush_emit;
			last <= cmd.flush_emit && sts.flush_done;
			if (cmd.flush_emit) fl_q <= sts.flush_done ? '0 : fl_q + 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.flush_emit) begin
			row_lane <= 5'(fl_q);
			row_value <= fp32_to_bf16(acc_vld_q[fl_q] ? acc_q[fl_q] : 32'd0);
		end
	end
	assign sts.flush_done = ({{(32-LANE_IW){1'b0}}, fl_q} == 32'(LANES - 1));

endmodule

// ----- hw/rtl/sell_block_matvec_accumulate_bf16.sv -----
// Top level of the SELL slice sparse matrix-vector multiply, bf16 in, fp32 sums.
//  channel | signals                                     | handshake
//  command | kind, lane, column_index, operand_bits       | start & !busy
//  result  | row_lane, row_value, last                    | result_valid, one cycle
// x write and preload are taken in the idle state; a nonzero goes through x RAM read,
// multiply, align, add and normalize-round in turn, through one shared fp32 adder path.
// A flush gives one result per cycle from the lane array, lanes in order.
// Reset clears the lane sums to +0 at once; the x RAM is not cleared.
// The receiver cannot stall; results are dropped if not taken.
module sell_block_matvec_accumulate_bf16 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [4:0]  lane,
	input  logic [11:0] column_index,
	input  logic [15:0] operand_bits,
	output logic        result_valid,
	output logic [4:0]  row_lane,
	output logic [15:0] row_value,
	output logic        last
);
	import smva_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	smva_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .kind(kind),
		.sts(sts), .cmd(cmd), .busy(busy)
	);

	smva_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .kind(kind), .lane(lane),
		.column_index(column_index), .operand_bits(operand_bits), .sts(sts),
		.result_valid(result_valid), .row_lane(row_lane),
		.row_value(row_value), .last(last)
	);

endmodule

// ----- hw/rtl/smva_chk.sv -----
// Port-level checker for the SELL matvec block, bound to the top level.
module smva_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  kind,
	input logic        result_valid,
	input logic [4:0]  row_lane,
	input logic        last
);
	import smva_pkg::*;

	// A non-flush transfer never starts a result stream
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind != KIND_FLUSH) |=> ##1 !result_valid)
		else $error("result after non-flush transfer");

	// Lanes come out in order
	a_lane_order: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last) |=> (result_valid && row_lane == $past(row_lane) + 5'd1))
		else $error("flush lane order broken");

	// last only on final lane
	a_last_lane: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> (result_valid && row_lane == 5'(LANES - 1)))
		else $error("last on wrong lane");

	// Busy stays high while results stream
	a_busy_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last) |-> busy)
		else $error("idle during flush");

endmodule

bind sell_block_matvec_accumulate_bf16 smva_chk u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
	.result_valid(result_valid), .row_lane(row_lane), .last(last)
);
